// File: rtl/dmcs_pkg.sv
// dmcs_pkg: shared types and constants of the decaying max cross stencil unit
// beat payloads, line memory entry, geometry and result push bundles
// no dependencies
package dmcs_pkg;

	localparam int LEVEL_W      = 5;
	localparam int SPAWN_DRAW_W = 12;
	localparam int SPAWN_LVL_W  = 4;
	localparam int DECAY_W      = 3;
	localparam int FW_W         = 8;
	localparam int FH_W         = 10;
	localparam int CFG_DATA_W   = 10;
	localparam int CFG_INDEX_W  = 1;

	localparam int DEF_MAX_ROW_CELLS = 128;
	localparam int MIN_DIM           = 3;
	localparam int OUT_DEPTH         = 4;
	localparam int OUT_PTR_W         = 2;
	localparam int OUT_CNT_W         = 3;

	localparam logic [FW_W-1:0] RESET_WIDTH  = 8'd120;
	localparam logic [FH_W-1:0] RESET_HEIGHT = 10'd80;

	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

	typedef struct packed {
		logic [LEVEL_W-1:0]      cell_level;
		logic [SPAWN_DRAW_W-1:0] spawn_draw;
		logic [SPAWN_LVL_W-1:0]  spawn_level;
		logic [DECAY_W-1:0]      decay_draw;
	} cell_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] new_level;
		logic               last_of_frame;
	} result_t;

	// one column of the two line buffers
	typedef struct packed {
		logic [LEVEL_W-1:0] upper;
		logic [LEVEL_W-1:0] middle;
	} line_entry_t;

	// effective frame geometry and restart strobe
	typedef struct packed {
		logic [FW_W-1:0] width;
		logic [FH_W-1:0] height;
		logic            restart;
	} geom_t;

	// up to two results per input beat, first in order first
	typedef struct packed {
		logic    first_valid;
		result_t first;
		logic    second_valid;
		result_t second;
	} push_t;

endpackage

// File: rtl/decaying_max_cross_stencil_unit.sv
// decaying_max_cross_stencil_unit: top level of the firework automaton stencil
// holds the geometry registers; uses dmcs_pkg, dmcs_stencil and dmcs_out_fifo

// Takes one frame of cell levels in raster order and returns the next generation,
// one row behind the input, border cells as zero; cells of the last row also
// return their own border cell, and the final result of a frame carries
// last_of_frame. A cell is taken every cycle while the result queue has room; both
// line buffers sit in one memory with one write and one prefetch read per cell,
// and a result passes the stencil stage register and the result queue. In the
// last row each cell yields two results through the single result port.
// A write to frame_width or frame_height restarts the frame; write only while
// the block is idle. The line memory needs no clearing after reset.
module decaying_max_cross_stencil_unit
	import dmcs_pkg::*;
#(
	parameter int MAX_ROW_CELLS = DEF_MAX_ROW_CELLS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   cell_valid,
	output logic                   cell_ready,
	input  cell_t                  cell_item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result
);

	logic [FW_W-1:0]      frame_width_q;
	logic [FH_W-1:0]      frame_height_q;
	logic [FW_W-1:0]      width_lo;
	geom_t                geom;
	push_t                push;
	logic [OUT_CNT_W-1:0] fifo_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_WIDTH;
			frame_height_q <= RESET_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IDX_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_IDX_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp geometry to what the line memory and the stencil can handle
	always_comb begin
		width_lo = (frame_width_q < FW_W'(MIN_DIM)) ? FW_W'(MIN_DIM) : frame_width_q;
		geom.width = (32'(width_lo) > MAX_ROW_CELLS) ? FW_W'(MAX_ROW_CELLS) : width_lo;
		geom.height = (frame_height_q < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height_q;
		geom.restart = cfg_write;
	end

	dmcs_stencil #(
		.MAX_ROW_CELLS (MAX_ROW_CELLS)
	) u_stencil (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom),
		.cell_valid (cell_valid),
		.cell_item  (cell_item),
		.cell_ready (cell_ready),
		.fifo_count (fifo_count),
		.push       (push)
	);

	dmcs_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.count        (fifo_count),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: rtl/dmcs_line_mem.sv
// dmcs_line_mem: line buffer memory, one column of both rows per entry
// one write port, one registered read port; uses dmcs_pkg
module dmcs_line_mem
	import dmcs_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_ROW_CELLS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  line_entry_t       wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output line_entry_t       rd_data
);

	line_entry_t mem [DEPTH];
	line_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/dmcs_stencil.sv
// dmcs_stencil: raster counters, line memory read-modify-write and stencil stage
// uses dmcs_pkg and dmcs_line_mem
module dmcs_stencil
	import dmcs_pkg::*;
#(
	parameter int MAX_ROW_CELLS = DEF_MAX_ROW_CELLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  geom_t                geom,
	input  logic                 cell_valid,
	input  cell_t                cell_item,
	output logic                 cell_ready,
	input  logic [OUT_CNT_W-1:0] fifo_count,
	output push_t                push
);

	localparam int CW = $clog2(MAX_ROW_CELLS);
	localparam int WW = (CW + 1 > FW_W + 1) ? CW + 1 : FW_W + 1;

	logic [CW-1:0]   col_q;
	logic [FH_W-1:0] row_q;
	logic [LEVEL_W-1:0] prev_center_q;

	logic        accept;
	logic        last_col;
	logic        last_row;
	logic [CW-1:0] rd_addr;
	line_entry_t rd_data;
	line_entry_t wr_data;

	logic                    valid_s1;
	logic                    main_s1;
	logic                    border_s1;
	logic                    edge_s1;
	logic                    last_s1;
	logic [LEVEL_W-1:0]      up_s1;
	logic [LEVEL_W-1:0]      center_s1;
	logic [LEVEL_W-1:0]      left_s1;
	logic [LEVEL_W-1:0]      down_s1;
	logic [SPAWN_DRAW_W-1:0] spawn_draw_s1;
	logic [SPAWN_LVL_W-1:0]  spawn_level_s1;
	logic [DECAY_W-1:0]      decay_s1;

	logic [LEVEL_W-1:0] max_a;
	logic [LEVEL_W-1:0] max_b;
	logic [LEVEL_W-1:0] max_c;
	logic [LEVEL_W-1:0] max_all;
	logic [LEVEL_W-1:0] decay;
	logic [LEVEL_W-1:0] level;
	logic [OUT_CNT_W-1:0] pending;

	assign last_col = (WW'(col_q) + WW'(1)) >= WW'(geom.width);
	assign last_row = ({1'b0, row_q} + 11'd1) >= {1'b0, geom.height};

	// results still to be pushed by the stencil stage count against fifo room
	assign pending = valid_s1 ? OUT_CNT_W'(main_s1) + OUT_CNT_W'(edge_s1) : '0;
	assign cell_ready = (fifo_count + pending) <= OUT_CNT_W'(OUT_DEPTH - 2);
	assign accept = cell_valid && cell_ready;

	// prefetch the column to the right; it also serves the next beat as its own column
	assign rd_addr = last_col ? '0 : col_q + CW'(1);
	assign wr_data = '{upper: rd_data.middle, middle: cell_item.cell_level};

	dmcs_line_mem #(
		.DEPTH (MAX_ROW_CELLS),
		.AW    (CW)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_q),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (geom.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + FH_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_center_q  <= rd_data.middle;
			main_s1        <= (row_q != '0);
			border_s1      <= (row_q == FH_W'(1)) || (col_q == '0) || last_col;
			edge_s1        <= last_row;
			last_s1        <= last_col;
			up_s1          <= rd_data.upper;
			center_s1      <= rd_data.middle;
			left_s1        <= prev_center_q;
			down_s1        <= cell_item.cell_level;
			spawn_draw_s1  <= cell_item.spawn_draw;
			spawn_level_s1 <= cell_item.spawn_level;
			decay_s1       <= cell_item.decay_draw;
		end
	end

	// right neighbour is the prefetched entry, now in the read register
	always_comb begin
		max_a   = (up_s1 > center_s1) ? up_s1 : center_s1;
		max_b   = (left_s1 > rd_data.middle) ? left_s1 : rd_data.middle;
		max_c   = (max_a > max_b) ? max_a : max_b;
		max_all = (max_c > down_s1) ? max_c : down_s1;
		decay   = LEVEL_W'(decay_s1) + LEVEL_W'(1);
		if (border_s1) begin
			level = '0;
		end else if (max_all == '0) begin
			level = (spawn_draw_s1 == '0) ? {1'b1, spawn_level_s1} : '0;
		end else begin
			level = (max_all > decay) ? max_all - decay : '0;
		end
	end

	always_comb begin
		push.first_valid  = valid_s1 && main_s1;
		push.first        = '{new_level: level, last_of_frame: 1'b0};
		push.second_valid = valid_s1 && edge_s1;
		push.second       = '{new_level: '0, last_of_frame: last_s1};
	end

	no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> rd_addr != col_q)
		else $error("line memory read and write hit the same column");

	col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> WW'(col_q) < WW'(geom.width))
		else $error("column count beyond frame width");

	row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_col && !geom.restart) |=> col_q == '0)
		else $error("column count did not wrap at end of row");

endmodule

// File: rtl/dmcs_out_fifo.sv
// dmcs_out_fifo: small result queue taking up to two beats per cycle
// decouples the stencil stage from the result port; uses dmcs_pkg
module dmcs_out_fifo
	import dmcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  push_t                push,
	output logic [OUT_CNT_W-1:0] count,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result
);

	result_t              mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic [OUT_CNT_W-1:0] npush;
	logic [OUT_PTR_W-1:0] second_ptr;
	logic                 pop;

	assign npush        = OUT_CNT_W'(push.first_valid) + OUT_CNT_W'(push.second_valid);
	assign second_ptr   = push.first_valid ? wr_ptr_q + OUT_PTR_W'(1) : wr_ptr_q;
	assign result_valid = (count_q != '0);
	assign result       = mem_q[rd_ptr_q];
	assign pop          = result_valid && result_ready;
	assign count        = count_q;

	always_ff @(posedge clk) begin
		if (push.first_valid) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.second_valid) begin
			mem_q[second_ptr] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(npush);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			count_q <= count_q + npush - OUT_CNT_W'(pop);
		end
	end

	no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q + npush - OUT_CNT_W'(pop)) <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result queue overflow");

endmodule
